// ===== hw/rtl/lss_pkg.sv =====
// Shared types and constants of the 3x3 Laplacian sharpening unit.
`default_nettype none

package lss_pkg;

  // Field and register widths
  localparam int unsigned PixW       = 8;
  localparam int unsigned CfgWidthW  = 11;
  localparam int unsigned CfgHeightW = 12;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 12;

  // Column index width in commands, wide enough for the largest supported line
  localparam int unsigned ColW = 13;

  // Default line store depth
  localparam int unsigned MaxWidthDefault = 1024;

  // Queue depths
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  // Register reset values and pixel ceiling
  localparam logic [CfgWidthW-1:0]  WidthReset  = 11'd640;
  localparam logic [CfgHeightW-1:0] HeightReset = 12'd480;
  localparam logic [PixW-1:0]       PixMax      = 8'd255;

  // Configuration register map
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  // Input beat
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            flush;
  } pix_in_t;

  // Result beat
  typedef struct packed {
    logic [PixW-1:0] out_pixel;
    logic            frame_last;
  } pix_out_t;

  // Classified step handed from front to back
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic [ColW-1:0] col;
    logic            emit;
    logic            interior;
    logic            last;
  } cmd_t;

  // Back pipeline occupancy
  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } back_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lss_fifo.sv =====
// Small register-based queue with occupancy count.
`default_nettype none

module lss_fifo #(
  parameter int unsigned Depth = 4,
  parameter type T = logic
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         wr_i,
  input  wire T                             wr_data_i,
  output logic                              full_o,
  input  wire logic                         rd_i,
  output T                                  rd_data_o,
  output logic                              empty_o,
  output logic [$clog2(Depth + 1)-1:0]      count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T              mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            wr_en, rd_en;

  assign wr_en = wr_i && !full_o;
  assign rd_en = rd_i && !empty_o;

  // Advance pointers and count
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    if (wr_en) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (rd_en) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    count_d = count_q + CntW'(wr_en) - CntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rptr_q];
  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign count_o   = count_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lss_front.sv =====
// Front end: configuration registers, raster counters and step classification.
`default_nettype none

module lss_front import lss_pkg::*; #(
  parameter int unsigned MaxWidth = MaxWidthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  input  wire logic                 push_i,
  input  wire pix_in_t              pix_i,
  input  wire logic                 cmd_full_i,
  output logic                      cmd_push_o,
  output cmd_t                      cmd_o
);

  localparam int unsigned AW   = $clog2(MaxWidth);
  localparam int unsigned CmpW = (AW + 1 > CfgWidthW) ? AW + 1 : CfgWidthW;
  localparam int unsigned RowW = CfgHeightW;

  logic [CfgWidthW-1:0]  width_q, width_d;
  logic [CfgHeightW-1:0] height_q, height_d;
  logic [AW-1:0]         in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0]       in_row_q, in_row_d, out_row_q, out_row_d;
  logic                  drain_q, drain_d;

  logic [CmpW-1:0]       fw, w_eff;
  logic [RowW-1:0]       h_eff;
  logic                  in_col_last, out_col_last, in_row_last, out_row_last;
  logic                  step, emit, last_in, interior, last_out;

  assign cfg_ready_o = 1'b1;

  // Clamp the frame size into the supported range
  always_comb begin
    fw = CmpW'(width_q);
    if (fw == '0) begin
      w_eff = CmpW'(1);
    end else if (fw > CmpW'(MaxWidth)) begin
      w_eff = CmpW'(MaxWidth);
    end else begin
      w_eff = fw;
    end
    h_eff = (height_q == '0) ? RowW'(1) : height_q;
  end

  // Edge tests on the counters
  assign in_col_last  = (CmpW'(in_col_q) + CmpW'(1)) >= w_eff;
  assign out_col_last = (CmpW'(out_col_q) + CmpW'(1)) >= w_eff;
  assign in_row_last  = ({1'b0, in_row_q} + (RowW + 1)'(1)) >= {1'b0, h_eff};
  assign out_row_last = ({1'b0, out_row_q} + (RowW + 1)'(1)) >= {1'b0, h_eff};

  // Classify the beat: a flush outside the drain is dropped
  assign step     = push_i && !cmd_full_i && !(pix_i.flush && !drain_q);
  assign emit     = (in_row_q >= RowW'(2)) || ((in_row_q == RowW'(1)) && (in_col_q != '0));
  assign last_in  = !drain_q && in_row_last && in_col_last;
  assign interior = (out_row_q != '0) && !out_row_last && (out_col_q != '0) && !out_col_last;
  assign last_out = out_row_last && out_col_last;

  // Advance the raster counters
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    drain_d   = drain_q;
    if (step) begin
      if (in_col_last) begin
        in_col_d = '0;
        if (in_row_q != '1) begin
          in_row_d = in_row_q + RowW'(1);
        end
      end else begin
        in_col_d = in_col_q + AW'(1);
      end
      if (last_in) begin
        drain_d = 1'b1;
      end
      if (emit) begin
        if (last_out) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
          drain_d   = 1'b0;
        end else if (out_col_last) begin
          out_col_d = '0;
          out_row_d = out_row_q + RowW'(1);
        end else begin
          out_col_d = out_col_q + AW'(1);
        end
      end
    end
  end

  // Decode configuration writes
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_WIDTH: begin
          width_d = cfg_data_i[CfgWidthW-1:0];
        end
        CFG_FRAME_HEIGHT: begin
          height_d = cfg_data_i[CfgHeightW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WidthReset;
      height_q  <= HeightReset;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      drain_q   <= 1'b0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      drain_q   <= drain_d;
    end
  end

  // Build the command; drain steps carry a zero pixel
  assign cmd_push_o     = step;
  assign cmd_o.pixel    = drain_q ? '0 : pix_i.pixel;
  assign cmd_o.col      = ColW'(in_col_q);
  assign cmd_o.emit     = emit;
  assign cmd_o.interior = interior;
  assign cmd_o.last     = last_out;

endmodule

`default_nettype wire

// ===== hw/rtl/lss_back.sv =====
// Back end: line stores, 3x3 window and sharpening datapath.
`default_nettype none

module lss_back import lss_pkg::*; #(
  parameter int unsigned MaxWidth = MaxWidthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_empty_i,
  input  wire cmd_t               cmd_i,
  output logic                    cmd_pop_o,
  input  wire logic [OutCntW-1:0] out_count_i,
  output logic                    out_push_o,
  output pix_out_t                out_data_o,
  output back_stat_t              stat_o
);

  localparam int unsigned AW    = $clog2(MaxWidth);
  localparam int unsigned LoadW = OutCntW + 1;
  localparam int unsigned SumW  = PixW + 2;

  typedef struct packed {
    logic [PixW-1:0] up;
    logic [PixW-1:0] mid;
  } line_t;

  typedef struct packed {
    logic [PixW-1:0] c;
    logic [PixW-1:0] n;
    logic [PixW-1:0] s;
    logic [PixW-1:0] w;
    logic [PixW-1:0] e;
    logic            interior;
    logic            last;
  } tap_t;

  line_t line_mem_q [MaxWidth];
  line_t rd_q, byp_data_q, rd_eff;
  logic  byp_q;

  logic  s1_valid_q, s2_valid_q;
  cmd_t  s1_cmd_q;
  tap_t  s2_q;

  logic [2:0][2:0][PixW-1:0] window_q, window_d;

  logic [LoadW-1:0] load;
  logic             adv, pop, s1_fire;
  logic [AW-1:0]    s1_col, new_col;

  logic [SumW-1:0]  quad, nsum, lap;
  logic [SumW:0]    sum;

  // Move only when the result queue has room for everything in flight
  assign load    = LoadW'(out_count_i) + LoadW'(s1_valid_q) + LoadW'(s2_valid_q);
  assign adv     = load < LoadW'(OutDepth);
  assign pop     = adv && !cmd_empty_i;
  assign s1_fire = adv && s1_valid_q;
  assign s1_col  = s1_cmd_q.col[AW-1:0];
  assign new_col = cmd_i.col[AW-1:0];

  assign cmd_pop_o = pop;

  // Take the write of the previous step when both hit the same column
  assign rd_eff = byp_q ? byp_data_q : rd_q;

  // Line stores: read for the popped step, write for the step in stage one
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_mem_q[s1_col] <= line_t'({rd_eff.mid, s1_cmd_q.pixel});
    end
    if (pop) begin
      rd_q       <= line_mem_q[new_col];
      byp_data_q <= line_t'({rd_eff.mid, s1_cmd_q.pixel});
      s1_cmd_q   <= cmd_i;
    end
  end

  // Shift the window by one column
  always_comb begin
    window_d = window_q;
    if (s1_fire) begin
      for (int r = 0; r < 3; r++) begin
        window_d[r][0] = window_q[r][1];
        window_d[r][1] = window_q[r][2];
      end
      window_d[0][2] = rd_eff.up;
      window_d[1][2] = rd_eff.mid;
      window_d[2][2] = s1_cmd_q.pixel;
    end
  end

  // Capture the taps of every step leaving stage one
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_q.c        <= window_d[1][1];
      s2_q.n        <= window_d[0][1];
      s2_q.s        <= window_d[2][1];
      s2_q.w        <= window_d[1][0];
      s2_q.e        <= window_d[1][2];
      s2_q.interior <= s1_cmd_q.interior;
      s2_q.last     <= s1_cmd_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      byp_q      <= 1'b0;
      window_q   <= '0;
    end else begin
      window_q <= window_d;
      if (adv) begin
        s1_valid_q <= pop;
        s2_valid_q <= s1_fire && s1_cmd_q.emit;
      end
      if (pop) begin
        byp_q <= s1_fire && (s1_col == new_col);
      end
    end
  end

  // Sharpen: clamp the Laplacian at zero, add the center, saturate; border pixels pass unchanged
  always_comb begin
    quad = {s2_q.c, 2'b00};
    nsum = SumW'(s2_q.n) + SumW'(s2_q.s) + SumW'(s2_q.w) + SumW'(s2_q.e);
    lap  = (quad > nsum) ? quad - nsum : '0;
    sum  = {1'b0, lap} + (SumW + 1)'(s2_q.c);
  end

  assign out_push_o           = adv && s2_valid_q;
  assign out_data_o.out_pixel = !s2_q.interior ? s2_q.c :
                                (sum > (SumW + 1)'(PixMax)) ? PixMax : sum[PixW-1:0];
  assign out_data_o.frame_last = s2_q.last;

  assign stat_o.s1_valid = s1_valid_q;
  assign stat_o.s2_valid = s2_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/laplacian_sharpen_3x3_unit.sv =====
// A beat passes the command queue and back stages one and two before its result is queued;
// the result for raster position k is emitted by input step k + W + 1 (W = effective width).
// Throughput: one beat per cycle unless stalled, set by a line store read and write per cycle.
// Reset (async, active low): counters, window, queues cleared; width 640, height 480.
// Line stores are not cleared and hold unknown data until written.
`default_nettype none

module laplacian_sharpen_3x3_unit import lss_pkg::*; #(
  parameter int unsigned MaxWidth = MaxWidthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                push,
  output logic                     full,
  input  wire pix_in_t             pix_i,
  output logic                     empty,
  input  wire logic                pop,
  output pix_out_t                 res_o
);

  localparam int unsigned CmdCntW = $clog2(CmdDepth + 1);

  logic               cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t               cmd_wr, cmd_rd;
  logic [CmdCntW-1:0] cmd_count;
  logic               out_push, out_full;
  pix_out_t           out_wr;
  logic [OutCntW-1:0] out_count;
  back_stat_t         back_stat;

  // Accept and classify beats
  lss_front #(
    .MaxWidth(MaxWidth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .pix_i      (pix_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr)
  );

  // Decouple front and back
  lss_fifo #(
    .Depth(CmdDepth),
    .T    (cmd_t)
  ) u_cmd_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (cmd_push),
    .wr_data_i(cmd_wr),
    .full_o   (cmd_full),
    .rd_i     (cmd_pop),
    .rd_data_o(cmd_rd),
    .empty_o  (cmd_empty),
    .count_o  (cmd_count)
  );

  // Filter datapath
  lss_back #(
    .MaxWidth(MaxWidth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_rd),
    .cmd_pop_o  (cmd_pop),
    .out_count_i(out_count),
    .out_push_o (out_push),
    .out_data_o (out_wr),
    .stat_o     (back_stat)
  );

  // Hold results until taken
  lss_fifo #(
    .Depth(OutDepth),
    .T    (pix_out_t)
  ) u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (out_push),
    .wr_data_i(out_wr),
    .full_o   (out_full),
    .rd_i     (pop),
    .rd_data_o(res_o),
    .empty_o  (empty),
    .count_o  (out_count)
  );

  assign full = cmd_full;

  // Queue plus back pipeline never holds more results than the queue can take
  logic [OutCntW:0] inflight;
  assign inflight = (OutCntW + 1)'(out_count) + (OutCntW + 1)'(back_stat.s1_valid)
                  + (OutCntW + 1)'(back_stat.s2_valid);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight <= (OutCntW + 1)'(OutDepth))
    else $error("result credit exceeded");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("result pushed into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> (!cmd_empty && (cmd_count != '0)))
    else $error("command popped from empty queue");

endmodule

`default_nettype wire

// ===== sim/laplacian_sharpen_3x3_unit_tb.sv =====
// Self-checking testbench for the 3x3 Laplacian sharpening unit: framed pixel streams with drains.
`timescale 1ns / 1ps

module laplacian_sharpen_3x3_unit_tb;
  import lss_pkg::*;

  // Tracks the filter state and holds the pixels the block still owes
  class sharpen_tracker;
    logic [CfgWidthW-1:0]  width_reg;
    logic [CfgHeightW-1:0] height_reg;
    logic [PixW-1:0]       upper_line [MaxWidthDefault];
    logic [PixW-1:0]       middle_line [MaxWidthDefault];
    logic [PixW-1:0]       win [3][3];
    logic [CfgWidthW-1:0]  in_col;
    logic [CfgWidthW-1:0]  out_col;
    logic [CfgHeightW-1:0] in_row;
    logic [CfgHeightW-1:0] out_row;
    bit                    draining;
    pix_out_t              due_pixels [$];
    int unsigned           faults;

    function new();
      width_reg = WidthReset;
      height_reg = HeightReset;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      in_col = '0;
      out_col = '0;
      in_row = '0;
      out_row = '0;
      draining = 1'b0;
      faults = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MaxWidthDefault) return MaxWidthDefault;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int unsigned pending();
      return due_pixels.size();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CFG_FRAME_WIDTH) width_reg = data[CfgWidthW-1:0];
      else if (idx == CFG_FRAME_HEIGHT) height_reg = data[CfgHeightW-1:0];
    endfunction

    // 4c minus the cross neighbours, clamp at zero, add c, saturate
    function logic [PixW-1:0] sharpen_center();
      int c;
      int lap;
      int v;
      c = int'(win[1][1]);
      lap = 4 * c - int'(win[0][1]) - int'(win[2][1]) - int'(win[1][0]) - int'(win[1][2]);
      if (lap < 0) lap = 0;
      v = lap + c;
      if (v > int'(PixMax)) v = int'(PixMax);
      return v[PixW-1:0];
    endfunction

    // Advance the window by one accepted beat and queue the pixel it releases
    function void take_pixel(pix_in_t beat);
      int unsigned w;
      int unsigned h;
      int unsigned idx;
      logic [PixW-1:0] px;
      logic [PixW-1:0] up;
      logic [PixW-1:0] mid;
      bit emit;
      bit last_in;
      bit interior;
      bit last_out;
      pix_out_t res;
      w = eff_width();
      h = eff_height();
      // Drop a flush outside the drain
      if (!draining && beat.flush) return;
      px = draining ? '0 : beat.pixel;
      idx = (in_col < MaxWidthDefault) ? in_col : MaxWidthDefault - 1;
      up = upper_line[idx];
      mid = middle_line[idx];
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = px;
      upper_line[idx] = mid;
      middle_line[idx] = px;

      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      last_in = !draining && (in_row + 1 >= h) && (in_col + 1 >= w);
      if (in_col + 1 >= w) begin
        in_col = '0;
        if (in_row != '1) in_row = in_row + 1'b1;
      end else begin
        in_col = in_col + 1'b1;
      end
      if (last_in) draining = 1'b1;
      if (!emit) return;

      interior = out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w;
      last_out = out_row + 1 >= h && out_col + 1 >= w;
      res.out_pixel = interior ? sharpen_center() : win[1][1];
      res.frame_last = last_out;
      due_pixels.push_back(res);
      if (last_out) begin
        in_col = '0;
        in_row = '0;
        out_col = '0;
        out_row = '0;
        draining = 1'b0;
      end else if (out_col + 1 >= w) begin
        out_col = '0;
        out_row = out_row + 1'b1;
      end else begin
        out_col = out_col + 1'b1;
      end
    endfunction

    // Compare one popped pixel with the oldest one due
    function void match_result(pix_out_t got);
      pix_out_t want;
      if (due_pixels.size() == 0) begin
        $error("result with nothing due: out_pixel %0d frame_last %0d",
               got.out_pixel, got.frame_last);
        faults++;
        return;
      end
      want = due_pixels.pop_front();
      if (got.out_pixel !== want.out_pixel) begin
        $error("out_pixel: expected %0d, actual %0d", want.out_pixel, got.out_pixel);
        faults++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last: expected %0d, actual %0d", want.frame_last, got.frame_last);
        faults++;
      end
    endfunction
  endclass

  localparam int unsigned ClkHalf     = 10;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned SettleGap   = 12;
  localparam int unsigned QuietLimit  = 3000;
  localparam int unsigned PhaseBeats  = 300;

  // Indexes outside the register map, written to check they are ignored
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                push        = 1'b0;
  logic                full;
  pix_in_t             pix_i       = '0;
  logic                empty;
  logic                pop         = 1'b0;
  pix_out_t            res_o;

  sharpen_tracker      sb = new();
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         phase_beats = 0;
  int unsigned         quiet_cycles = 0;
  logic [PixW-1:0]     frame_script [$];

  laplacian_sharpen_3x3_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .pix_i       (pix_i),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_o)
  );

  always #ClkHalf clk_i = ~clk_i;

  // Stall the result side at random
  always @(negedge clk_i) begin
    pop = rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Sample every handshake at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (push && !full) sb.take_pixel(pix_i);
      if (pop && !empty) sb.match_result(res_o);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("laplacian_sharpen_3x3_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [PixW-1:0] random_pixel();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? PixMax : '0;
    return PixW'($urandom);
  endfunction

  // Offer one beat, with random idle cycles first; returns at a falling edge
  task automatic send_item(input pix_in_t beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push = 1'b0;
      pix_i = pix_in_t'($urandom);
      @(negedge clk_i);
    end
    push = 1'b1;
    pix_i = beat;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold the input and wait until every due pixel has left the block
  task automatic settle();
    push = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SettleGap) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Reprogram the frame size on an idle block; a single register only for small frames
  task automatic set_sizes(input logic [CfgDataW-1:0] wdata, input logic [CfgDataW-1:0] hdata,
                           input bit both);
    int unsigned pick;
    pick = (both || sb.eff_width() > 16 || sb.eff_height() > 10) ?
           $urandom_range(0, 1) : $urandom_range(0, 3);
    settle();
    if ($urandom_range(0, 4) == 0) begin
      write_reg($urandom_range(0, 1) ? CfgSpareA : CfgSpareB, CfgDataW'($urandom));
    end
    case (pick)
      0: begin
        write_reg(CFG_FRAME_WIDTH, wdata);
        write_reg(CFG_FRAME_HEIGHT, hdata);
      end
      1: begin
        write_reg(CFG_FRAME_HEIGHT, hdata);
        write_reg(CFG_FRAME_WIDTH, wdata);
      end
      2: write_reg(CFG_FRAME_WIDTH, wdata);
      default: write_reg(CFG_FRAME_HEIGHT, hdata);
    endcase
    cfg_valid_i = 1'b0;
  endtask

  // Send one frame: scripted or random pixels with stray flushes, then the drain beats
  task automatic run_frame();
    int unsigned npix;
    int unsigned ndrain;
    logic [PixW-1:0] px;
    npix = sb.eff_width() * sb.eff_height();
    ndrain = sb.eff_width() + 1;
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(pix_in_t'{pixel: random_pixel(), flush: 1'b1});
      px = (frame_script.size() != 0) ? frame_script.pop_front() : random_pixel();
      send_item(pix_in_t'{pixel: px, flush: 1'b0});
    end
    // Drain with a mix of flushes and pixels that count as flushes
    for (int unsigned i = 0; i < ndrain; i++) begin
      send_item(pix_in_t'{pixel: random_pixel(), flush: 1'($urandom_range(0, 1))});
    end
    if ($urandom_range(0, 7) == 0) send_item(pix_in_t'{pixel: random_pixel(), flush: 1'b1});
    phase_beats += npix + ndrain;
  endtask

  initial begin
    logic [CfgDataW-1:0] wdata;
    logic [CfgDataW-1:0] hdata;
    logic [CfgDataW-1:0] ext_w;
    logic [CfgDataW-1:0] ext_h;

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: 4x3 frame with a saturating and a clamped interior pixel
    write_reg(CFG_FRAME_WIDTH, 12'd4);
    write_reg(CFG_FRAME_HEIGHT, 12'd3);
    cfg_valid_i = 1'b0;
    send_item(pix_in_t'{pixel: PixMax, flush: 1'b1});
    frame_script = '{PixMax, 8'h00, 8'h00, 8'h00,
                     8'h00, PixMax, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'h00, PixMax};
    run_frame();

    // Directed: zero width and zero height act as a single pixel
    settle();
    write_reg(CFG_FRAME_WIDTH, 12'd0);
    write_reg(CFG_FRAME_HEIGHT, 12'd0);
    cfg_valid_i = 1'b0;
    frame_script = '{8'd200};
    run_frame();

    // Random phases, each opening with one extreme frame shape
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          ext_w = 12'd64;
          ext_h = 12'd3;
        end
        1: begin
          send_idle_pct = 81;
          recv_stall_pct = 0;
          ext_w = 12'd0;
          ext_h = 12'd5;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 81;
          ext_w = 12'd1;
          ext_h = 12'd60;
        end
        default: begin
          send_idle_pct = 7;
          recv_stall_pct = 7;
          ext_w = 12'h81E;
          ext_h = 12'd1;
        end
      endcase
      set_sizes(ext_w, ext_h, 1'b1);
      run_frame();
      phase_beats = 0;
      while (phase_beats < PhaseBeats) begin
        if ($urandom_range(0, 1) == 0 || sb.eff_width() * sb.eff_height() > 200) begin
          wdata = ($urandom_range(0, 9) == 0) ? CfgDataW'($urandom_range(0, 2)) :
                                                CfgDataW'($urandom_range(1, 14));
          if ($urandom_range(0, 5) == 0) wdata[CfgDataW-1] = 1'b1;
          hdata = ($urandom_range(0, 9) == 0) ? '0 : CfgDataW'($urandom_range(1, 9));
          set_sizes(wdata, hdata, 1'b0);
        end
        run_frame();
      end
    end

    settle();
    if (sb.faults == 0) begin
      $display("laplacian_sharpen_3x3_unit regression: pass");
    end else begin
      $display("laplacian_sharpen_3x3_unit regression: fail");
    end
    $finish;
  end

endmodule
